// ===== sv/shp_pkg.sv =====
// Package for the stream handshake responder: sizes, phase and command codes,
// and the structs passed between its modules. No dependencies.
package shp_pkg;

    // Length of the C1 random field, echoed back in S2
    localparam int RANDOM_BYTES = 1528;

    localparam int C0C1_LEN = 9 + RANDOM_BYTES;
    localparam int C2_LEN   = 8 + RANDOM_BYTES;
    localparam int RESP_LEN = 1 + 2 * (8 + RANDOM_BYTES);

    localparam int CNT_W  = $clog2(RESP_LEN);
    localparam int ADDR_W = $clog2(RANDOM_BYTES);

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Byte positions in each phase
    localparam cnt_t C0C1_LAST   = cnt_t'(C0C1_LEN - 1);
    localparam cnt_t C2_LAST     = cnt_t'(C2_LEN - 1);
    localparam cnt_t RESP_LAST   = cnt_t'(RESP_LEN - 1);
    localparam cnt_t S1_TIME_END = cnt_t'(5);
    localparam cnt_t S1_ZERO_END = cnt_t'(9);
    localparam cnt_t S1_RAND_END = cnt_t'(9 + RANDOM_BYTES);
    localparam cnt_t S2_CTS_END  = cnt_t'(13 + RANDOM_BYTES);
    localparam cnt_t S2_STS_END  = cnt_t'(17 + RANDOM_BYTES);
    localparam cnt_t C1_RAND_BASE = cnt_t'(9);

    localparam logic [7:0] VERSION_RESET = 8'h03;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_C0C1 = 3'd0,
        PH_SEND      = 3'd1,
        PH_WAIT_C2   = 3'd2,
        PH_DONE      = 3'd3,
        PH_FAILED    = 3'd4
    } phase_t;

    // Result of one transaction before the echo byte is merged in
    typedef struct packed {
        logic       accepted;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] phase;
        logic       echo_sel;
    } shp_res_t;

    // Echo store access request
    typedef struct packed {
        logic       we;
        addr_t      waddr;
        logic [7:0] wdata;
        logic       re;
        addr_t      raddr;
    } shp_ram_req_t;

endpackage

// ===== sv/shp_echo_ram.sv =====
// Echo store: C1 random bytes, written during C0C1 and read during S2.
// Depends on shp_pkg.
module shp_echo_ram (
    input  logic                 aclk,
    input  shp_pkg::shp_ram_req_t req,
    output logic [7:0]           rd_data
);

    logic [7:0] mem [shp_pkg::RANDOM_BYTES];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/shp_ctrl.sv =====
// Handshake sequencer: phase, byte counter, timestamps and S0S1S2 byte selection.
// Depends on shp_pkg.
module shp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  acc,
    input  logic                  cmd,
    input  logic [7:0]            rx_byte,
    input  logic [31:0]           server_time,
    input  logic [7:0]            random_byte,
    input  logic [7:0]            version,
    output shp_pkg::shp_res_t     res,
    output shp_pkg::shp_ram_req_t ram_req
);

    shp_pkg::phase_t phase_reg, phase_next;
    shp_pkg::cnt_t   count_reg, count_next;
    logic [31:0]     client_ts_reg, client_ts_next;
    logic [31:0]     server_ts_reg, server_ts_next;
    logic            bad_reg, bad_next;

    shp_pkg::cnt_t   k;
    logic            offer_c0c1, offer_c2, fetch_send;

    function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    assign k          = count_reg;
    assign offer_c0c1 = (cmd == shp_pkg::CMD_OFFER) && (phase_reg == shp_pkg::PH_WAIT_C0C1);
    assign offer_c2   = (cmd == shp_pkg::CMD_OFFER) && (phase_reg == shp_pkg::PH_WAIT_C2);
    assign fetch_send = (cmd == shp_pkg::CMD_FETCH) && (phase_reg == shp_pkg::PH_SEND);

    // Next state
    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        client_ts_next = client_ts_reg;
        server_ts_next = server_ts_reg;
        bad_next       = bad_reg;
        if (offer_c0c1) begin
            if (k == '0) begin
                bad_next = (rx_byte != version);
            end else if (k < shp_pkg::S1_TIME_END) begin
                client_ts_next = {client_ts_reg[23:0], rx_byte};
            end
            if (k == shp_pkg::C0C1_LAST) begin
                count_next = '0;
                phase_next = bad_reg ? shp_pkg::PH_FAILED : shp_pkg::PH_SEND;
            end else begin
                count_next = k + 1'b1;
            end
        end else if (offer_c2) begin
            if (k == shp_pkg::C2_LAST) begin
                count_next = '0;
                phase_next = shp_pkg::PH_DONE;
            end else begin
                count_next = k + 1'b1;
            end
        end else if (fetch_send) begin
            if (k == '0) begin
                server_ts_next = server_time;
            end
            if (k == shp_pkg::RESP_LAST) begin
                count_next = '0;
                phase_next = shp_pkg::PH_WAIT_C2;
            end else begin
                count_next = k + 1'b1;
            end
        end
    end

    // Result and echo store access
    always_comb begin
        shp_pkg::cnt_t cts_off;
        shp_pkg::cnt_t sts_off;
        shp_pkg::cnt_t echo_off;
        shp_pkg::cnt_t wr_off;
        cts_off  = k - shp_pkg::S1_RAND_END;
        sts_off  = k - shp_pkg::S2_CTS_END;
        echo_off = k - shp_pkg::S2_STS_END;
        wr_off   = k - shp_pkg::C1_RAND_BASE;

        res          = '0;
        res.accepted = offer_c0c1 || offer_c2;
        res.phase    = 3'(phase_next);
        ram_req      = '0;
        ram_req.waddr = wr_off[shp_pkg::ADDR_W-1:0];
        ram_req.wdata = rx_byte;
        ram_req.raddr = echo_off[shp_pkg::ADDR_W-1:0];

        // Store the C1 random field
        ram_req.we = acc && offer_c0c1 && (k >= shp_pkg::C1_RAND_BASE);

        if (fetch_send) begin
            res.tx_valid = 1'b1;
            res.tx_last  = (k == shp_pkg::RESP_LAST);
            if (k == '0) begin
                res.tx_byte = version;
            end else if (k < shp_pkg::S1_TIME_END) begin
                res.tx_byte = be_byte(server_ts_reg, 2'(k - 1'b1));
            end else if (k < shp_pkg::S1_ZERO_END) begin
                res.tx_byte = 8'h00;
            end else if (k < shp_pkg::S1_RAND_END) begin
                res.tx_byte = random_byte;
            end else if (k < shp_pkg::S2_CTS_END) begin
                res.tx_byte = be_byte(client_ts_reg, cts_off[1:0]);
            end else if (k < shp_pkg::S2_STS_END) begin
                res.tx_byte = be_byte(server_ts_reg, sts_off[1:0]);
            end else begin
                res.echo_sel = 1'b1;
                ram_req.re   = acc;
            end
        end
    end

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= shp_pkg::PH_WAIT_C0C1;
            count_reg     <= '0;
            client_ts_reg <= '0;
            server_ts_reg <= '0;
            bad_reg       <= 1'b0;
        end else if (acc) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            client_ts_reg <= client_ts_next;
            server_ts_reg <= server_ts_next;
            bad_reg       <= bad_next;
        end
    end

endmodule

// ===== sv/shp_pipe.sv =====
// Two-register result path: decoded stage and output register, with echo merge.
// Depends on shp_pkg.
module shp_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              acc,
    input  shp_pkg::shp_res_t res,
    input  logic [7:0]        echo_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_accepted,
    output logic              m_tx_valid,
    output logic [7:0]        m_tx_byte,
    output logic              m_tx_last,
    output logic [2:0]        m_phase
);

    logic              s1_valid_reg;
    shp_pkg::shp_res_t s1_res_reg;
    logic              m_valid_reg;
    logic              m_accepted_reg;
    logic              m_tx_valid_reg;
    logic [7:0]        m_tx_byte_reg;
    logic              m_tx_last_reg;
    logic [2:0]        m_phase_reg;
    logic              s1_adv;

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign acc     = s_valid && s_ready;

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Capture decoded transaction
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_res_reg <= res;
        end
    end

    // Load output register, merging the echo store byte
    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_accepted_reg <= s1_res_reg.accepted;
            m_tx_valid_reg <= s1_res_reg.tx_valid;
            m_tx_byte_reg  <= s1_res_reg.echo_sel ? echo_data : s1_res_reg.tx_byte;
            m_tx_last_reg  <= s1_res_reg.tx_last;
            m_phase_reg    <= s1_res_reg.phase;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_accepted = m_accepted_reg;
    assign m_tx_valid = m_tx_valid_reg;
    assign m_tx_byte  = m_tx_byte_reg;
    assign m_tx_last  = m_tx_last_reg;
    assign m_phase    = m_phase_reg;

endmodule

// ===== sv/stream_handshake_responder.sv =====
// Top level of the stream handshake responder (server side, simple handshake).
// Depends on shp_pkg, shp_ctrl, shp_echo_ram and shp_pipe.
//
//   channel  | ports                                                  | role
//   ---------+--------------------------------------------------------+-------------------
//   s_       | s_valid s_ready s_cmd s_rx_byte s_server_time          | command in
//            | s_random_byte                                          |
//   m_       | m_valid m_ready m_accepted m_tx_valid m_tx_byte        | one result out
//            | m_tx_last m_phase                                      |
//   cfg_     | cfg_valid cfg_ready cfg_wdata                          | expected version
//
// One transaction is accepted per cycle while s_ready is high; its result passes through
// the decoded stage and then the output register, allowing for the registered echo store read used for S2.
// Reset returns to waiting for C0C1 and sets the expected version to 3.
// A stalled output holds both stages; input ready drops only when both are full.
module stream_handshake_responder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_server_time,
    input  logic [7:0]  s_random_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_last,
    output logic [2:0]  m_phase,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_wdata
);

    logic                  acc;
    logic [7:0]            version_reg;
    logic [7:0]            echo_data;
    shp_pkg::shp_res_t     res;
    shp_pkg::shp_ram_req_t ram_req;

    assign cfg_ready = 1'b1;

    // Hold the expected version register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= shp_pkg::VERSION_RESET;
        end else if (cfg_valid && cfg_ready) begin
            version_reg <= cfg_wdata;
        end
    end

    shp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .acc         (acc),
        .cmd         (s_cmd),
        .rx_byte     (s_rx_byte),
        .server_time (s_server_time),
        .random_byte (s_random_byte),
        .version     (version_reg),
        .res         (res),
        .ram_req     (ram_req)
    );

    shp_echo_ram u_echo_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (echo_data)
    );

    shp_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .acc        (acc),
        .res        (res),
        .echo_data  (echo_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_accepted (m_accepted),
        .m_tx_valid (m_tx_valid),
        .m_tx_byte  (m_tx_byte),
        .m_tx_last  (m_tx_last),
        .m_phase    (m_phase)
    );

endmodule
